[hw/rtl/pht_pkg.sv]
// ----------------------------------------------------------------------------
// pht_pkg
// Shared widths, constants and the result record of the path hash table.
// ----------------------------------------------------------------------------
package pht_pkg;

   localparam int BYTE_W     = 8;
   localparam int ENTRY_ID_W = 16;
   localparam int SLOT_W     = 10;
   localparam int HASH_W     = 32;
   localparam int LOG2_W     = 4;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [HASH_W-1:0] HASH_START = 32'd5381;
   localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd10;

   // register index taken from the word address
   localparam logic REG_TABLE_LOG2 = 1'b0;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic [HASH_W-1:0] final_hash;
      logic              table_full;
   } pht_result_type;

endpackage

[hw/rtl/pht_hash.sv]
// ----------------------------------------------------------------------------
// pht_hash
// Running djb2 hash over the path bytes, restarted after the last byte.
// ----------------------------------------------------------------------------
module pht_hash (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           last_byte,
   input  logic [pht_pkg::BYTE_W-1:0]     path_byte,
   output logic [pht_pkg::HASH_W-1:0]     hash_next
);

   logic [pht_pkg::HASH_W-1:0] running_hash_ff;
   logic [pht_pkg::HASH_W-1:0] running_hash_in;
   logic [pht_pkg::HASH_W-1:0] byte_sext;

   // byte taken as two's complement
   assign byte_sext = {{(pht_pkg::HASH_W - pht_pkg::BYTE_W){path_byte[pht_pkg::BYTE_W-1]}},
                       path_byte};
   assign hash_next = (running_hash_ff << 5) + running_hash_ff + byte_sext;

   always_comb begin
      running_hash_in = running_hash_ff;
      if (accept) begin
         running_hash_in = last_byte ? pht_pkg::HASH_START : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= pht_pkg::HASH_START;
      end else begin
         running_hash_ff <= running_hash_in;
      end
   end

endmodule

[hw/rtl/pht_table.sv]
// ----------------------------------------------------------------------------
// pht_table
// Slot table: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pht_table #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pht_ctrl.sv]
// ----------------------------------------------------------------------------
// pht_ctrl
// Clearing pass, triangular probe walk and insert into the slot table.
// ----------------------------------------------------------------------------
module pht_ctrl #(
   parameter int MAX_SLOTS  = 1024,
   parameter int ENTRY_BITS = 16,
   parameter int AW         = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pht_pkg::LOG2_W-1:0]        table_log2,
   input  logic                              start,
   input  logic [pht_pkg::HASH_W-1:0]        hash_final,
   input  logic [pht_pkg::ENTRY_ID_W-1:0]    entry_id,
   input  logic                              out_free,
   output logic                              req_ready,
   output logic                              load_result,
   output pht_pkg::pht_result_type           result,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output logic [ENTRY_BITS-1:0]             wr_data,
   output logic                              rd_en,
   output logic [AW-1:0]                     rd_addr,
   input  logic [ENTRY_BITS-1:0]             rd_data
);

   localparam int LOG_MAX = $clog2(MAX_SLOTS + 1) - 1;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_PROBE  = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [AW-1:0]               bucket_ff, bucket_in;
   logic [AW:0]                 step_ff, step_in;
   logic [AW:0]                 probes_ff, probes_in;
   logic [pht_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [ENTRY_BITS-1:0]       entry_ff, entry_in;
   logic                        full_ff, full_in;

   logic [pht_pkg::LOG2_W-1:0]  log2_eff;
   logic [AW:0]                 size;
   logic [AW-1:0]               mask;
   logic [AW:0]                 next_sum;

   // clamp table size to the memory depth
   assign log2_eff = (32'(table_log2) > LOG_MAX) ? pht_pkg::LOG2_W'(LOG_MAX) : table_log2;
   assign size     = (AW + 1)'(1) << log2_eff;
   assign mask     = AW'(size - (AW + 1)'(1));
   assign next_sum = {1'b0, bucket_ff} + step_ff;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      bucket_in   = bucket_ff;
      step_in     = step_ff;
      probes_in   = probes_ff;
      hash_in     = hash_ff;
      entry_in    = entry_ff;
      full_in     = full_ff;
      wr_en       = 1'b0;
      wr_addr     = bucket_ff;
      wr_data     = entry_ff;
      rd_en       = 1'b0;
      load_result = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '1;
            if (clr_ff == AW'(MAX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               hash_in   = hash_final;
               entry_in  = ENTRY_BITS'(entry_id);
               bucket_in = AW'(hash_final) & mask;
               step_in   = (AW + 1)'(1);
               probes_in = '0;
               rd_en     = 1'b1;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (rd_data == '1) begin
               wr_en    = 1'b1;
               full_in  = 1'b0;
               state_in = ST_RESULT;
            end else if (probes_ff + (AW + 1)'(1) == size) begin
               full_in  = 1'b1;
               state_in = ST_RESULT;
            end else begin
               probes_in = probes_ff + (AW + 1)'(1);
               bucket_in = next_sum[AW-1:0] & mask;
               step_in   = step_ff + (AW + 1)'(1);
               rd_en     = 1'b1;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               load_result = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rd_addr = bucket_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign result.slot_index = full_ff ? '0 : pht_pkg::SLOT_W'(bucket_ff);
   assign result.final_hash = hash_ff;
   assign result.table_full = full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff <= bucket_in;
      step_ff   <= step_in;
      probes_ff <= probes_in;
      hash_ff   <= hash_in;
      entry_ff  <= entry_in;
      full_ff   <= full_in;
   end

endmodule

[hw/rtl/path_hash_table_insert.sv]
// ----------------------------------------------------------------------------
// path_hash_table_insert
// djb2 path hash with insert into an open-addressed slot table.
// ----------------------------------------------------------------------------
// Throughput: a byte that is not the last one is taken every cycle while the block is idle.
// Insert: after the last byte the block makes P probes (1 up to the table
//    size), one per cycle as the single read port of the slot table allows,
//    then loads the response register once it is free; input stalls meanwhile.
// Reset: synchronous; after it a clearing pass writes every slot empty,
//    with req_tready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
module path_hash_table_insert #(
   parameter int MAX_SLOTS  = 1024,
   parameter int ENTRY_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // path_byte[7:0], entry_id[23:8]
   input  logic                          req_tlast,  // last_byte
   // response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,  // slot_index[9:0], final_hash[41:10], zero
   output logic                          rsp_tuser,  // table_full
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pht_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pht_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pht_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int AW = $clog2(MAX_SLOTS);

   logic                               req_accept;
   logic                               start;
   logic [pht_pkg::HASH_W-1:0]         hash_next;
   logic                               out_free;
   logic                               load_result;
   pht_pkg::pht_result_type            result;

   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic [ENTRY_BITS-1:0]              wr_data;
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic [ENTRY_BITS-1:0]              rd_data;

   logic [pht_pkg::LOG2_W-1:0]         table_log2_ff, table_log2_in;
   logic                               csr_write;

   logic                               rsp_valid_ff, rsp_valid_in;
   pht_pkg::pht_result_type            rsp_data_ff, rsp_data_in;

   // ---- register port: one register, table_log2, at word zero ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      table_log2_in = table_log2_ff;
      if (csr_write && (csr_paddr[2] == pht_pkg::REG_TABLE_LOG2)) begin
         table_log2_in = csr_pwdata[pht_pkg::LOG2_W-1:0];
      end
   end

   // words beyond the register list read as zero
   assign csr_prdata = (csr_paddr[2] == pht_pkg::REG_TABLE_LOG2) ?
                       (pht_pkg::CSR_DW)'(table_log2_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_log2_ff <= pht_pkg::LOG2_RESET;
      end else begin
         table_log2_ff <= table_log2_in;
      end
   end

   // ---- request side ----
   assign req_accept = req_tvalid && req_tready;
   assign start      = req_accept && req_tlast;

   pht_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .last_byte (req_tlast),
      .path_byte (req_tdata[7:0]),
      .hash_next (hash_next)
   );

   // ---- probe sequencer and slot table ----
   pht_ctrl #(
      .MAX_SLOTS  (MAX_SLOTS),
      .ENTRY_BITS (ENTRY_BITS),
      .AW         (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .table_log2  (table_log2_ff),
      .start       (start),
      .hash_final  (hash_next),
      .entry_id    (req_tdata[23:8]),
      .out_free    (out_free),
      .req_ready   (req_tready),
      .load_result (load_result),
      .result      (result),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   pht_table #(
      .DEPTH (MAX_SLOTS),
      .AW    (AW),
      .DW    (ENTRY_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- response register: hold the transaction until the sink takes it ----
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         // drop the delivered transaction
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.final_hash, rsp_data_ff.slot_index};
   assign rsp_tuser  = rsp_data_ff.table_full;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for path_hash_table_insert. Path bytes go in as stream
// transactions, and a local djb2 hash and slot-table image predict every
// insert. Each response transaction is checked field by field against the
// oldest prediction. A short table of directed rows comes first. Random paths
// follow over a range of table sizes, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;

   localparam int  HALF_PERIOD  = 2;
   localparam int  RESET_CYCLES = 5;
   localparam int  CYCLE_LIMIT  = 6000000;     // every insert walking 1024 slots
   localparam int  SETTLE       = 8;
   localparam int  N_DIRECTED   = 21;
   localparam int  N_RANDOM     = 1080;
   localparam int  N_PHASES     = 11;
   localparam int  MAX_LOG2     = 10;          // 1024 slots in the table
   localparam logic [pht_pkg::ENTRY_ID_W-1:0] EMPTY_SLOT = '1;
   localparam logic [pht_pkg::CSR_AW-1:0] TABLE_LOG2_ADDR =
      pht_pkg::CSR_AW'(4 * pht_pkg::REG_TABLE_LOG2);

   // one directed row: optional register write first, then one request
   typedef struct {
      bit                             cfg_write;
      logic [pht_pkg::LOG2_W-1:0]     cfg_value;
      logic [pht_pkg::BYTE_W-1:0]     pbyte;
      logic                           is_last;
      logic [pht_pkg::ENTRY_ID_W-1:0] entry;
      bit                             typed;        // expectation typed in below
      logic [pht_pkg::SLOT_W-1:0]     slot;
      logic [pht_pkg::HASH_W-1:0]     hash;
      logic                           full;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [23:0]                    req_tdata;       // path_byte[7:0], entry_id[23:8]
   logic                           req_tlast;       // last_byte
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [47:0]                    rsp_tdata;       // slot_index[9:0], final_hash[41:10], zero
   logic                           rsp_tuser;       // table_full
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [pht_pkg::CSR_AW-1:0]     csr_paddr;
   logic [pht_pkg::CSR_DW-1:0]     csr_pwdata;
   logic [pht_pkg::CSR_DW-1:0]     csr_prdata;
   logic                           csr_pready;

   // predictor state: running hash, image of the slot table, size register
   logic [pht_pkg::HASH_W-1:0]     hash_acc;
   logic [pht_pkg::ENTRY_ID_W-1:0] slot_image [1024];
   logic [pht_pkg::LOG2_W-1:0]     log2_setting;

   pht_pkg::pht_result_type        pending_inserts [$];
   stim_row_type                   directed_rows [N_DIRECTED];

   int                    errors       = 0;
   int                    bytes_sent   = 0;
   int                    inserts_seen = 0;
   int                    fulls_seen   = 0;
   int                    cycle_count  = 0;
   int                    rsp_stall_left = 0;
   bit                    quiet_tail   = 1'b0;

   path_hash_table_insert u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Abandon the run if it stalls well past the slowest legal schedule.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d inserts outstanding",
                  cycle_count, pending_inserts.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Hash one byte; on the last byte probe the table image as the block does.
   // Return 1 when the byte produces a response.
   function automatic bit hash_and_probe(input logic [pht_pkg::BYTE_W-1:0] pbyte,
                                         input logic is_last,
                                         input logic [pht_pkg::ENTRY_ID_W-1:0] entry,
                                         output pht_pkg::pht_result_type res);
      logic [pht_pkg::HASH_W-1:0] h;
      logic [pht_pkg::LOG2_W-1:0] lg;
      int unsigned                size;
      int unsigned                mask;
      int unsigned                bucket;
      int unsigned                step;
      bit                         found;
      h = (hash_acc << 5) + hash_acc
          + {{(pht_pkg::HASH_W-pht_pkg::BYTE_W){pbyte[pht_pkg::BYTE_W-1]}}, pbyte};
      res = '0;
      if (!is_last) begin
         hash_acc = h;
         return 1'b0;
      end
      hash_acc = pht_pkg::HASH_START;
      // sizes beyond the table fold back to the full table
      lg = log2_setting;
      if (lg > MAX_LOG2) lg = pht_pkg::LOG2_W'(MAX_LOG2);
      size   = 1 << lg;
      mask   = size - 1;
      bucket = h & mask;
      step   = 1;
      found  = 1'b0;
      for (int unsigned p = 0; p < size; p++) begin
         if (slot_image[bucket] == EMPTY_SLOT) begin
            found = 1'b1;
            break;
         end
         bucket = (bucket + step) & mask;
         step++;
      end
      res.final_hash = h;
      if (found) begin
         slot_image[bucket] = entry;
         res.slot_index = pht_pkg::SLOT_W'(bucket);
         res.table_full = 1'b0;
      end else begin
         res.slot_index = '0;
         res.table_full = 1'b1;
      end
      return 1'b1;
   endfunction

   // Drive one request transaction, optionally after a random gap, and record
   // the prediction once the block has taken it.
   task automatic send_byte(input logic [pht_pkg::BYTE_W-1:0] pbyte, input logic is_last,
                            input logic [pht_pkg::ENTRY_ID_W-1:0] entry, input bit typed,
                            input pht_pkg::pht_result_type typed_res);
      pht_pkg::pht_result_type res;
      int                      gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {entry, pbyte};
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (hash_and_probe(pbyte, is_last, entry, res))
         pending_inserts.push_back(typed ? typed_res : res);
   endtask

   // Hold the request stream idle until every insert has answered.
   task automatic drain_inserts;
      req_tvalid <= 1'b0;
      while (pending_inserts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register write: setup cycle, then access until pready.
   task automatic write_table_log2(input logic [pht_pkg::LOG2_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TABLE_LOG2_ADDR;
      csr_pwdata  <= pht_pkg::CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      log2_setting = value;
   endtask

   // Random path: mostly short, sometimes long; bytes either printable or raw.
   task automatic send_random_path(inout int budget);
      int                             len;
      logic [pht_pkg::BYTE_W-1:0]     pbyte;
      logic [pht_pkg::ENTRY_ID_W-1:0] entry;
      int                             pick;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         pbyte = ($urandom_range(0, 1) == 0) ? pht_pkg::BYTE_W'($urandom_range(32, 126))
                                             : pht_pkg::BYTE_W'($urandom);
         pick = $urandom_range(0, 19);
         if (pick == 0)      entry = '1;         // stored but still looks empty
         else if (pick == 1) entry = '0;
         else if (pick == 2) entry = 16'hFFFE;
         else                entry = pht_pkg::ENTRY_ID_W'($urandom);
         send_byte(pbyte, i == len - 1, entry, 1'b0, '0);
         budget--;
      end
   endtask

   // Response side: random stall bursts, none in the quiet tail.
   always @(posedge clock) begin
      if (quiet_tail) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall_left <= $urandom_range(0, 5);
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each response transaction against the oldest prediction.
   always @(posedge clock) begin
      pht_pkg::pht_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_inserts.size() == 0) begin
            $display("%0t: unexpected response slot=%0d hash=%h full=%b", $time,
                     rsp_tdata[9:0], rsp_tdata[41:10], rsp_tuser);
            errors++;
         end else begin
            want = pending_inserts.pop_front();
            inserts_seen++;
            if (rsp_tuser) fulls_seen++;
            if (rsp_tdata[9:0] !== want.slot_index) begin
               $display("%0t: slot_index expected %0d actual %0d", $time,
                        want.slot_index, rsp_tdata[9:0]);
               errors++;
            end
            if (rsp_tdata[41:10] !== want.final_hash) begin
               $display("%0t: final_hash expected %h actual %h", $time,
                        want.final_hash, rsp_tdata[41:10]);
               errors++;
            end
            if (rsp_tuser !== want.table_full) begin
               $display("%0t: table_full expected %b actual %b", $time,
                        want.table_full, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[47:42] !== '0) begin
               $display("%0t: tdata padding expected 0 actual %h", $time,
                        rsp_tdata[47:42]);
               errors++;
            end
         end
      end
   end

   initial begin
      pht_pkg::pht_result_type      typed_res;
      int                           budget;
      int                           per_phase;
      logic [pht_pkg::LOG2_W-1:0]   phase_log2 [N_PHASES];

      // Directed rows. Single-byte paths after reset hash to 5381*33 plus the
      // signed byte, so their slots can be read off directly.
      directed_rows = '{
         '{0, 0, 8'h00, 1, 16'h0000, 1, 10'd421, 32'd177573, 0},
         '{0, 0, 8'hFF, 1, 16'hFFFE, 1, 10'd420, 32'd177572, 0},
         '{0, 0, 8'h7F, 1, 16'h8001, 1, 10'd548, 32'd177700, 0},
         '{0, 0, 8'h80, 1, 16'h7FFF, 1, 10'd293, 32'd177445, 0},
         // same hash again: collide and step one slot on
         '{0, 0, 8'h00, 1, 16'h1234, 1, 10'd422, 32'd177573, 0},
         '{0, 0, 8'h2F, 0, 16'hFFFF, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'h61, 0, 16'h0000, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'h2F, 0, 16'hAAAA, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'h62, 1, 16'h5A5A, 0, 10'd0,   32'd0,      0},
         // all-ones entry lands two steps on and leaves the slot empty
         '{0, 0, 8'h00, 1, 16'hFFFF, 1, 10'd424, 32'd177573, 0},
         '{0, 0, 8'h00, 1, 16'h00FF, 1, 10'd424, 32'd177573, 0},
         // one-slot table: fill it, then hit the full case
         '{1, 0, 8'h55, 1, 16'hFFFF, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'hAA, 1, 16'hA5A5, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'h00, 1, 16'h0001, 1, 10'd0,   32'd177573, 1},
         '{0, 0, 8'hFF, 0, 16'h0F0F, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'hFF, 0, 16'hF0F0, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'hFF, 1, 16'h4321, 0, 10'd0,   32'd0,      0},
         // oversized setting folds back to the full table
         '{1, 15, 8'h00, 1, 16'h0002, 0, 10'd0,  32'd0,      0},
         '{1, 1, 8'h01, 1, 16'h0003, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'h02, 1, 16'h0004, 0, 10'd0,   32'd0,      0},
         '{0, 0, 8'h03, 1, 16'h0005, 0, 10'd0,   32'd0,      0}
      };
      phase_log2 = '{4'd15, 4'd2, 4'd10, 4'd5, 4'd1, 4'd11, 4'd7, 4'd0, 4'd9, 4'd3,
                     4'd10};

      // predictor state after reset
      hash_acc     = pht_pkg::HASH_START;
      log2_setting = pht_pkg::LOG2_RESET;
      foreach (slot_image[i]) slot_image[i] = EMPTY_SLOT;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; the clearing pass holds req_tready low.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg_write) begin
            drain_inserts();
            write_table_log2(directed_rows[i].cfg_value);
         end
         typed_res.slot_index = directed_rows[i].slot;
         typed_res.final_hash = directed_rows[i].hash;
         typed_res.table_full = directed_rows[i].full;
         send_byte(directed_rows[i].pbyte, directed_rows[i].is_last,
                   directed_rows[i].entry, directed_rows[i].typed, typed_res);
      end

      // Random phases, one table size each; the last one runs without idling.
      per_phase = N_RANDOM / N_PHASES;
      for (int p = 0; p < N_PHASES; p++) begin
         drain_inserts();
         write_table_log2(phase_log2[p]);
         if (p == N_PHASES - 1) quiet_tail = 1'b1;
         budget = per_phase;
         while (budget > 0) begin
            // now and then hold off until every insert has answered
            if (!quiet_tail && $urandom_range(0, 29) == 0) begin
               req_tvalid <= 1'b0;
               while (pending_inserts.size() != 0) @(posedge clock);
            end
            send_random_path(budget);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_inserts.size() != 0) @(posedge clock);
      repeat (SETTLE * 4) @(posedge clock);

      $display("tb: %0d path bytes sent, %0d inserts checked, %0d of them full",
               bytes_sent, inserts_seen, fulls_seen);
      $display("tb: table sizes from 1 to 1024 slots, oversized settings included");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", errors);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/pht_pkg.sv
hw/rtl/pht_hash.sv
hw/rtl/pht_table.sv
hw/rtl/pht_ctrl.sv
hw/rtl/path_hash_table_insert.sv
sim/tb.sv
